[hw/rtl/fdc16_pkg.sv]
package fdc16_pkg;

  localparam int unsigned HEADER_BYTES = 6;

  // configuration register indexes
  localparam logic [2:0] CFG_START_WORD  = 3'd0;
  localparam logic [2:0] CFG_SENSOR_TYPE = 3'd1;
  localparam logic [2:0] CFG_DEVICE_TYPE = 3'd2;
  localparam logic [2:0] CFG_CONTROL_TYPE = 3'd3;
  localparam logic [2:0] CFG_MAX_PAYLOAD = 3'd4;

  // message kinds
  localparam logic [1:0] MK_SENSOR  = 2'd0;
  localparam logic [1:0] MK_DEVICE  = 2'd1;
  localparam logic [1:0] MK_CONTROL = 2'd2;

  // end-of-frame status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_START = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_BAD_LEN   = 3'd3;
  localparam logic [2:0] ST_BAD_CRC   = 3'd4;

  // beat kinds on the result side
  localparam logic BK_PAYLOAD = 1'b0;
  localparam logic BK_END     = 1'b1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int unsigned OUT_TDATA_W = 64;

  // crc-16/modbus, one byte, reflected
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

[hw/rtl/frame_detector_with_crc16_core.sv]
// frame deframer with crc-16/modbus check, one received byte per beat
// throughput: one byte every cycle unless a held result is stalled; the crc
// byte update and the parse step sit between the parser state and the result
// register; a result appears on the master side in the cycle after its byte is taken
// reset: configuration returns to its defaults, parser goes idle, result register empties
module frame_detector_with_crc16_core #(
  parameter int unsigned MAX_PAYLOAD = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] frame_begin
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] payload_index, [13:6] payload_byte, [15:14] message_kind,
  // [31:16] length_field, [47:32] received_crc, [54:48] frame_bytes,
  // [57:55] status, [63:58] zero
  output logic [fdc16_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic        m_axis_tuser    // [0] kind
);

  localparam int unsigned CW = $clog2(fdc16_pkg::HEADER_BYTES + MAX_PAYLOAD + 3);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC
  } phase_e;

  // configuration
  logic [15:0] start_word_q, sensor_code_q, device_code_q, control_code_q;
  logic [6:0]  max_payload_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_word_q   <= 16'd0;
      sensor_code_q  <= 16'd1;
      device_code_q  <= 16'd2;
      control_code_q <= 16'd3;
      max_payload_q  <= 7'd40;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        fdc16_pkg::CFG_START_WORD:   start_word_q   <= cfg_wdata_i;
        fdc16_pkg::CFG_SENSOR_TYPE:  sensor_code_q  <= cfg_wdata_i;
        fdc16_pkg::CFG_DEVICE_TYPE:  device_code_q  <= cfg_wdata_i;
        fdc16_pkg::CFG_CONTROL_TYPE: control_code_q <= cfg_wdata_i;
        fdc16_pkg::CFG_MAX_PAYLOAD:  max_payload_q  <= cfg_wdata_i[6:0];
        default: ;
      endcase
    end
  end

  // parser state
  phase_e      phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  held_q, held_d;
  logic [15:0] len_q, len_d;
  logic [1:0]  mkind_q, mkind_d;
  logic [15:0] crcword_q, crcword_d;

  // result register
  logic        out_valid_q;
  logic        out_kind_q, out_kind_d;
  logic [5:0]  out_idx_q, out_idx_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [1:0]  out_mkind_q, out_mkind_d;
  logic [15:0] out_len_q, out_len_d;
  logic [15:0] out_crc_q, out_crc_d;
  logic [6:0]  out_fbytes_q, out_fbytes_d;
  logic [2:0]  out_status_q, out_status_d;
  logic        load;

  logic          accept;
  logic [7:0]    b;
  logic [15:0]   word;
  logic [15:0]   limit;
  logic [CW-1:0] len_c;
  logic [CW-1:0] idx;
  logic [15:0]   crc_next;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign b             = s_axis_tdata;
  assign word          = {b, held_q};
  assign crc_next      = fdc16_pkg::crc16_byte(crc_q, b);
  assign limit = (16'(max_payload_q) > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD)
                                                         : 16'(max_payload_q);
  // a length that passed the check fits the counter width
  assign len_c = len_q[CW-1:0];
  assign idx   = cnt_q - CW'(fdc16_pkg::HEADER_BYTES);

  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    crc_d        = crc_q;
    held_d       = held_q;
    len_d        = len_q;
    mkind_d      = mkind_q;
    crcword_d    = crcword_q;
    load         = 1'b0;
    out_kind_d   = fdc16_pkg::BK_END;
    out_idx_d    = 6'd0;
    out_byte_d   = 8'd0;
    out_mkind_d  = mkind_q;
    out_len_d    = len_q;
    out_crc_d    = crcword_q;
    out_fbytes_d = 7'd0;
    out_status_d = fdc16_pkg::ST_OK;

    if (accept) begin
      if (s_axis_tuser || phase_q == PH_IDLE) begin
        phase_d   = PH_HEADER;
        cnt_d     = CW'(1);
        crc_d     = fdc16_pkg::crc16_byte(fdc16_pkg::CRC_INIT, b);
        held_d    = b;
        len_d     = 16'd0;
        mkind_d   = fdc16_pkg::MK_SENSOR;
        crcword_d = 16'd0;
      end else begin
        unique case (phase_q)
          PH_HEADER: begin
            crc_d = crc_next;
            cnt_d = cnt_q + CW'(1);
            if (!cnt_q[0]) begin
              held_d = b;
            end else if (cnt_q == CW'(1)) begin
              if (word != start_word_q) begin
                load         = 1'b1;
                out_status_d = fdc16_pkg::ST_BAD_START;
              end
            end else if (cnt_q == CW'(3)) begin
              // sensor wins over device, device over control
              priority if (word == sensor_code_q) begin
                mkind_d = fdc16_pkg::MK_SENSOR;
              end else if (word == device_code_q) begin
                mkind_d = fdc16_pkg::MK_DEVICE;
              end else if (word == control_code_q) begin
                mkind_d = fdc16_pkg::MK_CONTROL;
              end else begin
                load         = 1'b1;
                out_status_d = fdc16_pkg::ST_BAD_TYPE;
              end
            end else begin
              len_d     = word;
              out_len_d = word;
              if (word < 16'd2 || (word - 16'd2) > limit) begin
                load         = 1'b1;
                out_status_d = fdc16_pkg::ST_BAD_LEN;
              end else begin
                phase_d = (word == 16'd2) ? PH_CRC : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_d        = crc_next;
            cnt_d        = cnt_q + CW'(1);
            load         = 1'b1;
            out_kind_d   = fdc16_pkg::BK_PAYLOAD;
            out_idx_d    = 6'(idx);
            out_byte_d   = (mkind_q == fdc16_pkg::MK_CONTROL && idx > CW'(1)) ? 8'd0 : b;
            out_crc_d    = 16'd0;
            if ((idx + CW'(1)) >= (len_c - CW'(2))) begin
              phase_d = PH_CRC;
            end
          end
          PH_CRC: begin
            cnt_d = cnt_q + CW'(1);
            if (cnt_d == CW'(fdc16_pkg::HEADER_BYTES) + len_c - CW'(1)) begin
              held_d = b;
            end else begin
              crcword_d    = word;
              out_crc_d    = word;
              load         = 1'b1;
              if (word == crc_q) begin
                out_status_d = fdc16_pkg::ST_OK;
                out_fbytes_d = 7'(cnt_d);
              end else begin
                out_status_d = fdc16_pkg::ST_BAD_CRC;
              end
            end
          end
          default: ;
        endcase
        // every end beat sends the parser back to idle
        if (load && out_kind_d == fdc16_pkg::BK_END) begin
          phase_d = PH_IDLE;
          cnt_d   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      crc_q       <= fdc16_pkg::CRC_INIT;
      held_q      <= 8'd0;
      len_q       <= 16'd0;
      mkind_q     <= fdc16_pkg::MK_SENSOR;
      crcword_q   <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      crc_q     <= crc_d;
      held_q    <= held_d;
      len_q     <= len_d;
      mkind_q   <= mkind_d;
      crcword_q <= crcword_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q   <= out_kind_d;
      out_idx_q    <= out_idx_d;
      out_byte_q   <= out_byte_d;
      out_mkind_q  <= out_mkind_d;
      out_len_q    <= out_len_d;
      out_crc_q    <= out_crc_d;
      out_fbytes_q <= out_fbytes_d;
      out_status_q <= out_status_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {6'd0, out_status_q, out_fbytes_q, out_crc_q, out_len_q,
                          out_mkind_q, out_byte_q, out_idx_q};

  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> cnt_q == '0)
    else $error("parser idle with nonzero byte count");

  a_payload_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !s_axis_tuser && phase_q == PH_PAYLOAD
      |=> m_axis_tvalid && m_axis_tuser == fdc16_pkg::BK_PAYLOAD)
    else $error("payload byte did not produce a payload beat");

  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> len_q > 16'd2 && len_q <= 16'(MAX_PAYLOAD + 2))
    else $error("payload phase with out-of-range length");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(fdc16_pkg::HEADER_BYTES + MAX_PAYLOAD + 2))
    else $error("byte counter past largest frame");

endmodule

[verif/frame_detector_with_crc16_core_tb.sv]
`timescale 1ns / 1ps

module frame_detector_with_crc16_core_tb;

  localparam int unsigned PAYLOAD_CAP = 64;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_BYTES = 170;
  localparam int unsigned DRAIN_LIMIT = 20000;
  // index with no register behind it, writes must be ignored
  localparam logic [2:0]  CFG_SPARE   = 3'd7;

  typedef enum logic [1:0] {AWAIT_FIRST, IN_HEADER, IN_PAYLOAD, IN_CHECKSUM} parse_phase_e;
  typedef enum logic [1:0] {FROM_ROW, CRC_LO, CRC_HI} byte_src_e;

  // ordered so that {tuser, tdata[57:0]} maps straight onto it
  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [6:0]  fbytes;
    logic [15:0] crc;
    logic [15:0] len;
    logic [1:0]  mkind;
    logic [7:0]  pbyte;
    logic [5:0]  index;
  } frame_res_t;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       typed;
    frame_res_t want;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
    byte_src_e  src;
    logic       typed;
    frame_res_t want;
  } dir_row_t;

  localparam frame_res_t NO_RES = '0;
  localparam frame_res_t E_START =
    '{fdc16_pkg::BK_END, fdc16_pkg::ST_BAD_START, 7'd0, 16'h0000, 16'h0000,
      fdc16_pkg::MK_SENSOR, 8'h00, 6'd0};
  localparam frame_res_t E_TYPE =
    '{fdc16_pkg::BK_END, fdc16_pkg::ST_BAD_TYPE, 7'd0, 16'h0000, 16'h0000,
      fdc16_pkg::MK_SENSOR, 8'h00, 6'd0};
  localparam frame_res_t E_SHORT =
    '{fdc16_pkg::BK_END, fdc16_pkg::ST_BAD_LEN, 7'd0, 16'h0000, 16'h0001,
      fdc16_pkg::MK_SENSOR, 8'h00, 6'd0};
  localparam frame_res_t E_LONG =
    '{fdc16_pkg::BK_END, fdc16_pkg::ST_BAD_LEN, 7'd0, 16'h0000, 16'hFFFF,
      fdc16_pkg::MK_DEVICE, 8'h00, 6'd0};

  // reset configuration: start 0, types 1/2/3, max payload 40
  localparam dir_row_t DIR_ROWS [27] = '{
    '{8'h12, 1'b1, FROM_ROW, 1'b0, NO_RES},
    '{8'h34, 1'b0, FROM_ROW, 1'b1, E_START},
    // byte in idle starts a frame without the begin flag
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'hFF, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'hFF, 1'b0, FROM_ROW, 1'b1, E_TYPE},
    '{8'h00, 1'b1, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h01, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h01, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b1, E_SHORT},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h02, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'hFF, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'hFF, 1'b0, FROM_ROW, 1'b1, E_LONG},
    // frame cut short by a forced begin, no result for it
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b1, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h03, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    // control frame with no payload, straight to the checksum
    '{8'h02, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, FROM_ROW, 1'b0, NO_RES},
    '{8'h00, 1'b0, CRC_LO,   1'b0, NO_RES},
    '{8'h00, 1'b0, CRC_HI,   1'b0, NO_RES}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = fdc16_pkg::CFG_START_WORD;
  logic [15:0] cfg_wdata_i = 16'h0000;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [fdc16_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic        m_axis_tuser;

  // typed expectation riding along with the byte on the bus
  logic        cur_typed = 1'b0;
  frame_res_t  cur_want = '0;

  // shadow of the configuration registers
  logic [15:0] cfg_start = 16'h0000;
  logic [15:0] cfg_sensor = 16'h0001;
  logic [15:0] cfg_device = 16'h0002;
  logic [15:0] cfg_control = 16'h0003;
  logic [6:0]  cfg_max_pay = 7'd40;

  // shadow of the parser state
  parse_phase_e ps_phase = AWAIT_FIRST;
  int unsigned  ps_count = 0;
  logic [15:0]  ps_crc = fdc16_pkg::CRC_INIT;
  logic [7:0]   ps_low = 8'h00;
  int unsigned  ps_len = 0;
  logic [1:0]   ps_kind = fdc16_pkg::MK_SENSOR;
  logic [15:0]  ps_crc_word = 16'h0000;

  frame_res_t  pending_results[$];
  rx_item_t    stim_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_cnt = 0;
  bit          hold_pending = 1'b0;
  bit          need_begin = 1'b0;

  frame_detector_with_crc16_core #(
    .MAX_PAYLOAD(PAYLOAD_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // bit-serial form of the reflected 0xA001 update
  function automatic logic [15:0] modbus_crc8(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] c;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ d[i]) ? ((c >> 1) ^ fdc16_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic bit close_frame(input logic [2:0] st, input int unsigned total,
                                     output frame_res_t r);
    r = '0;
    r.kind   = fdc16_pkg::BK_END;
    r.mkind  = ps_kind;
    r.len    = ps_len[15:0];
    r.crc    = ps_crc_word;
    r.fbytes = (st == fdc16_pkg::ST_OK) ? total[6:0] : 7'd0;
    r.status = st;
    ps_phase = AWAIT_FIRST;
    ps_count = 0;
    return 1'b1;
  endfunction

  // advances the parser shadow by one byte; returns 1 when a result beat is due
  function automatic bit deframe_byte(input logic [7:0] b, input logic force_first,
                                      output frame_res_t r);
    logic [15:0] word;
    int unsigned pos;
    int unsigned lim;
    r = '0;
    word = {b, ps_low};
    if (force_first || ps_phase == AWAIT_FIRST) begin
      ps_phase = IN_HEADER;
      ps_count = 1;
      ps_crc = modbus_crc8(fdc16_pkg::CRC_INIT, b);
      ps_low = b;
      ps_len = 0;
      ps_kind = fdc16_pkg::MK_SENSOR;
      ps_crc_word = 16'h0000;
      return 1'b0;
    end
    unique case (ps_phase)
      IN_HEADER: begin
        pos = ps_count;
        ps_crc = modbus_crc8(ps_crc, b);
        ps_count = pos + 1;
        if (!pos[0]) begin
          ps_low = b;
          return 1'b0;
        end
        if (pos == 1) begin
          if (word != cfg_start) return close_frame(fdc16_pkg::ST_BAD_START, 0, r);
        end else if (pos == 3) begin
          // sensor wins over device, device over control
          if (word == cfg_sensor) ps_kind = fdc16_pkg::MK_SENSOR;
          else if (word == cfg_device) ps_kind = fdc16_pkg::MK_DEVICE;
          else if (word == cfg_control) ps_kind = fdc16_pkg::MK_CONTROL;
          else return close_frame(fdc16_pkg::ST_BAD_TYPE, 0, r);
        end else begin
          lim = (cfg_max_pay > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg_max_pay;
          ps_len = word;
          if (word < 16'd2 || ps_len - 2 > lim) begin
            return close_frame(fdc16_pkg::ST_BAD_LEN, 0, r);
          end
          ps_phase = (word == 16'd2) ? IN_CHECKSUM : IN_PAYLOAD;
        end
        return 1'b0;
      end
      IN_PAYLOAD: begin
        pos = ps_count - fdc16_pkg::HEADER_BYTES;
        ps_crc = modbus_crc8(ps_crc, b);
        ps_count = ps_count + 1;
        r.kind  = fdc16_pkg::BK_PAYLOAD;
        r.index = pos[5:0];
        r.pbyte = (ps_kind == fdc16_pkg::MK_CONTROL && pos > 1) ? 8'h00 : b;
        r.mkind = ps_kind;
        r.len   = ps_len[15:0];
        if (pos + 1 >= ps_len - 2) ps_phase = IN_CHECKSUM;
        return 1'b1;
      end
      default: begin
        ps_count = ps_count + 1;
        if (ps_count == fdc16_pkg::HEADER_BYTES + ps_len - 1) begin
          ps_low = b;
          return 1'b0;
        end
        ps_crc_word = word;
        return close_frame((word == ps_crc) ? fdc16_pkg::ST_OK : fdc16_pkg::ST_BAD_CRC,
                           ps_count, r);
      end
    endcase
  endfunction

  function automatic string fmt_res(input frame_res_t r);
    return $sformatf("kind=%0d idx=%0d byte=%02h mk=%0d len=%04h crc=%04h bytes=%0d st=%0d",
                     r.kind, r.index, r.pbyte, r.mkind, r.len, r.crc, r.fbytes, r.status);
  endfunction

  function automatic void note_error(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch
    frame_res_t calc;
    frame_res_t got;
    frame_res_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (deframe_byte(s_axis_tdata, s_axis_tuser, calc)) begin
          pending_results.push_back(cur_typed ? cur_want : calc);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[57:0]};
        if (pending_results.size() == 0) begin
          note_error({"unexpected beat: ", fmt_res(got)});
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            note_error({"beat mismatch: exp ", fmt_res(want), " got ", fmt_res(got)});
          end
        end
      end
    end
  end

  // result side: random stalls, and a long hold on request
  initial begin : result_side
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8))
        @(posedge clk_i);
    end
  end

  task automatic send_item(input rx_item_t it, input bit calm);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.b;
    s_axis_tuser  <= it.first;
    cur_typed     <= it.typed;
    cur_want      <= it.want;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    unique case (idx)
      fdc16_pkg::CFG_START_WORD:   cfg_start = val;
      fdc16_pkg::CFG_SENSOR_TYPE:  cfg_sensor = val;
      fdc16_pkg::CFG_DEVICE_TYPE:  cfg_device = val;
      fdc16_pkg::CFG_CONTROL_TYPE: cfg_control = val;
      fdc16_pkg::CFG_MAX_PAYLOAD:  cfg_max_pay = val[6:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [15:0] sw, input logic [15:0] st,
                               input logic [15:0] dt, input logic [15:0] ct,
                               input logic [6:0] mp);
    put_reg(fdc16_pkg::CFG_START_WORD, sw);
    put_reg(fdc16_pkg::CFG_SENSOR_TYPE, st);
    put_reg(fdc16_pkg::CFG_DEVICE_TYPE, dt);
    put_reg(fdc16_pkg::CFG_CONTROL_TYPE, ct);
    // upper bits are outside the register and must be dropped
    put_reg(fdc16_pkg::CFG_MAX_PAYLOAD, {9'($urandom), mp});
    put_reg(CFG_SPARE, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  // wait for every outstanding beat, then let the block go quiet
  task automatic settle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      note_error($sformatf("%0d beats never arrived", pending_results.size()));
      mismatch_cnt += pending_results.size() - 1;
      pending_results.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // one frame, mostly well formed, sometimes cut, broken or plain noise
  task automatic queue_frame();
    logic [7:0]  fb[$];
    logic [15:0] sw;
    logic [15:0] tw;
    logic [15:0] lw;
    logic [15:0] chk;
    int unsigned lim;
    int unsigned sel;
    int unsigned cut;
    bit          noise;
    bit          cut_off;
    rx_item_t    it;
    lim = (cfg_max_pay > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg_max_pay;
    noise = ($urandom_range(0, 19) == 0);
    cut_off = 1'b0;
    if (noise) begin
      repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
    end else begin
      sw = ($urandom_range(0, 15) == 0) ? cfg_start ^ 16'($urandom_range(1, 65535))
                                        : cfg_start;
      sel = $urandom_range(0, 15);
      tw = (sel == 0) ? 16'($urandom) : (sel < 6) ? cfg_sensor
         : (sel < 11) ? cfg_device : cfg_control;
      sel = $urandom_range(0, 19);
      if (sel == 0) lw = 16'($urandom_range(0, 1));
      else if (sel == 1) lw = 16'(lim + 3 + $urandom_range(0, 4));
      else if (sel == 2) lw = 16'($urandom);
      else if (sel < 8) lw = 16'($urandom_range(0, lim) + 2);
      else lw = 16'($urandom_range(0, (lim < 6) ? lim : 6) + 2);
      fb.push_back(sw[7:0]);
      fb.push_back(sw[15:8]);
      if (sw == cfg_start) begin
        fb.push_back(tw[7:0]);
        fb.push_back(tw[15:8]);
        if (tw == cfg_sensor || tw == cfg_device || tw == cfg_control) begin
          fb.push_back(lw[7:0]);
          fb.push_back(lw[15:8]);
          if (lw >= 16'd2 && int'(lw) - 2 <= int'(lim)) begin
            repeat (int'(lw) - 2) begin
              sel = $urandom_range(0, 15);
              fb.push_back((sel == 0) ? 8'h00 : (sel == 1) ? 8'hFF : 8'($urandom));
            end
            chk = fdc16_pkg::CRC_INIT;
            foreach (fb[i]) chk = modbus_crc8(chk, fb[i]);
            if ($urandom_range(0, 7) == 0) chk = chk ^ (16'd1 << $urandom_range(0, 15));
            fb.push_back(chk[7:0]);
            fb.push_back(chk[15:8]);
          end
        end
      end
      if (fb.size() > 2 && $urandom_range(0, 19) == 0) begin
        cut = $urandom_range(1, fb.size() - 1);
        fb = fb[0:cut-1];
        cut_off = 1'b1;
      end
    end
    foreach (fb[i]) begin
      it.b = fb[i];
      if (i == 0) it.first = need_begin ? 1'b1 : 1'($urandom_range(0, 1));
      else it.first = noise ? ($urandom_range(0, 3) == 0) : 1'b0;
      it.typed = 1'b0;
      it.want = NO_RES;
      stim_q.push_back(it);
    end
    // the parser may be left mid-frame, so the next frame has to force its start
    need_begin = noise || cut_off;
  endtask

  initial begin : stimulus
    dir_row_t    row;
    rx_item_t    it;
    logic [15:0] run_crc;
    logic [15:0] code;
    int unsigned phase_start;
    bit          calm;
    run_crc = fdc16_pkg::CRC_INIT;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_ROWS[i]) begin
      row = DIR_ROWS[i];
      if (row.first) run_crc = fdc16_pkg::CRC_INIT;
      it.b = row.b;
      unique case (row.src)
        CRC_LO: it.b = run_crc[7:0];
        CRC_HI: it.b = run_crc[15:8];
        default: run_crc = modbus_crc8(run_crc, row.b);
      endcase
      it.first = row.first;
      it.typed = row.typed;
      it.want = row.want;
      send_item(it, 1'b0);
    end
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      code = 16'($urandom);
      unique case (ph)
        0: load_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 7'd64);
        1: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 7'd0);
        2: load_settings(16'($urandom), code, code, code, 7'($urandom_range(1, 64)));
        3: load_settings(16'hA5C3, 16'h0001, 16'h0002, 16'h0003, 7'd127);
        4: load_settings(16'($urandom), code, code, 16'($urandom), 7'd8);
        default: begin
          load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        7'($urandom_range(0, 64)));
        end
      endcase
      // result side holds off while bytes keep coming, input must back up
      if (ph == 1 || ph == 4) hold_pending = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        queue_frame();
        calm = ($urandom_range(0, 4) == 0);
        while (stim_q.size() != 0) send_item(stim_q.pop_front(), calm);
      end
      settle();
    end

    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fdc16_pkg.sv
hw/rtl/frame_detector_with_crc16_core.sv
verif/frame_detector_with_crc16_core_tb.sv
